>>> design/point_in_polygon_test_assert.svh
// assertion macros for the point-in-polygon test checker
`ifndef POINT_IN_POLYGON_TEST_ASSERT_SVH
`define POINT_IN_POLYGON_TEST_ASSERT_SVH
// property that must hold on every clock edge outside reset
`define PIP_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");
// implication whose consequent is checked in the cycle after the antecedent
`define PIP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

>>> design/pip_pkg.sv
// shared types and constants of the point-in-polygon test
package pip_pkg;
	localparam int COORD_W = 24;
	localparam int CNT_W = 7;
	localparam int MAX_VERTICES_DEF = 64;
	localparam int FRAC_BITS_DEF = 8;
	localparam int MIN_CORNERS = 3;

	localparam logic [1:0] FUNC_CLEAR = 2'd0;
	localparam logic [1:0] FUNC_APPEND = 2'd1;
	localparam logic [1:0] FUNC_QUERY = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FEW = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [1:0] func;
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
	} item_t;

	typedef struct packed {
		logic inside_res;
		logic [1:0] status;
		logic [CNT_W-1:0] vertex_count;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic latch;     // capture item
		logic wr_vertex; // append captured vertex
		logic clr;       // clear table
		logic rd;        // read edge at index
		logic eval;      // evaluate registered edge
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic full;
		logic few;
		logic stop;     // collinear edge seen
	} dp_stat_t;
endpackage

>>> design/pip_datapath.sv
// vertex memory, edge test pipeline and crossing parity
module pip_datapath #(
	parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
	parameter int IDX_W = $clog2(MAX_VERTICES)
) (
	input  logic clk,
	input  logic arst_n,
	input  pip_pkg::dp_cmd_t cmd,
	input  pip_pkg::item_t item,
	input  logic [IDX_W-1:0] rd_idx,
	input  logic rd_wrap,
	input  logic signed [pip_pkg::COORD_W-1:0] ray_end_x,
	output pip_pkg::dp_stat_t stat,
	output logic inside_q,
	output logic [IDX_W:0] count_q
);
	import pip_pkg::*;

	localparam int W = COORD_W + 1;
	localparam int P = 2 * W;

	logic signed [COORD_W-1:0] mem_x [MAX_VERTICES];
	logic signed [COORD_W-1:0] mem_y [MAX_VERTICES];
	logic signed [COORD_W-1:0] px_q, py_q, ex_q;
	logic signed [COORD_W-1:0] ax_s1, ay_s1, bx_s1, by_s1;
	logic v_s1;
	logic signed [COORD_W-1:0] first_x_q, first_y_q;
	logic [IDX_W-1:0] wr_idx;

	// stage 2 products
	logic signed [P-1:0] m1a_s2, m1b_s2, m2a_s2, m2b_s2, m3a_s2, m3b_s2;
	logic signed [P-1:0] m4a_s2, m4b_s2, m5a_s2, m5b_s2;
	logic bx1_s2, bx2_s2, bx3_s2, bx4_s2, bx5_s2, v_s2;
	logic parity_q, stop_q;

	assign wr_idx = count_q[IDX_W-1:0];
	assign stat.full = (count_q >= (IDX_W+1)'(MAX_VERTICES));
	assign stat.few = (count_q < (IDX_W+1)'(MIN_CORNERS));
	assign stat.stop = stop_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_vertex) begin
			mem_x[wr_idx] <= item.coord_x;
			mem_y[wr_idx] <= item.coord_y;
		end
		if (cmd.rd) begin
			ax_s1 <= mem_x[rd_idx];
			ay_s1 <= mem_y[rd_idx];
			bx_s1 <= rd_wrap ? first_x_q : mem_x[rd_idx + IDX_W'(1)];
			by_s1 <= rd_wrap ? first_y_q : mem_y[rd_idx + IDX_W'(1)];
		end
		if (cmd.wr_vertex && count_q == '0) begin
			first_x_q <= item.coord_x;
			first_y_q <= item.coord_y;
		end
		if (cmd.latch) begin
			px_q <= item.coord_x;
			py_q <= item.coord_y;
			ex_q <= ray_end_x;
		end
	end

	function automatic logic signed [W-1:0] sx(input logic signed [COORD_W-1:0] v);
		return W'(v);
	endfunction

	function automatic logic in_box(input logic signed [COORD_W-1:0] ax, ay, bx, by, cx, cy);
		logic signed [COORD_W-1:0] xlo, xhi, ylo, yhi;
		xlo = (ax < cx) ? ax : cx;
		xhi = (ax < cx) ? cx : ax;
		ylo = (ay < cy) ? ay : cy;
		yhi = (ay < cy) ? cy : ay;
		return bx >= xlo && bx <= xhi && by >= ylo && by <= yhi;
	endfunction

	// turn sign from registered product pair: 0 collinear, 1 cw, 2 ccw
	function automatic logic [1:0] turn(input logic signed [P-1:0] a, b);
		logic signed [P:0] d;
		d = (P+1)'(a) - (P+1)'(b);
		if (d == '0) return 2'd0;
		return (d > 0) ? 2'd1 : 2'd2;
	endfunction

	// stage 2: orientation products, one multiplier per nonzero term
	always_ff @(posedge clk) begin
		// o1: a,b,p
		m1a_s2 <= (sx(by_s1) - sx(ay_s1)) * (sx(px_q) - sx(bx_s1));
		m1b_s2 <= (sx(bx_s1) - sx(ax_s1)) * (sx(py_q) - sx(by_s1));
		// o2: a,b,e
		m2a_s2 <= (sx(by_s1) - sx(ay_s1)) * (sx(ex_q) - sx(bx_s1));
		m2b_s2 <= (sx(bx_s1) - sx(ax_s1)) * (sx(py_q) - sx(by_s1));
		// o3: p,e,a (ray horizontal)
		m3a_s2 <= '0;
		m3b_s2 <= (sx(ex_q) - sx(px_q)) * (sx(ay_s1) - sx(py_q));
		// o4: p,e,b
		m4a_s2 <= '0;
		m4b_s2 <= (sx(ex_q) - sx(px_q)) * (sx(by_s1) - sx(py_q));
		// a,p,b
		m5a_s2 <= (sx(py_q) - sx(ay_s1)) * (sx(bx_s1) - sx(px_q));
		m5b_s2 <= (sx(px_q) - sx(ax_s1)) * (sx(by_s1) - sx(py_q));
		bx1_s2 <= in_box(ax_s1, ay_s1, px_q, py_q, bx_s1, by_s1);
		bx2_s2 <= in_box(ax_s1, ay_s1, ex_q, py_q, bx_s1, by_s1);
		bx3_s2 <= in_box(px_q, py_q, ax_s1, ay_s1, ex_q, py_q);
		bx4_s2 <= in_box(px_q, py_q, bx_s1, by_s1, ex_q, py_q);
		bx5_s2 <= in_box(ax_s1, ay_s1, px_q, py_q, bx_s1, by_s1);
		v_s2 <= v_s1 & cmd.eval;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= cmd.rd;
		end
	end

	logic [1:0] o1, o2, o3, o4, o5;
	logic meet;
	assign o1 = turn(m1a_s2, m1b_s2);
	assign o2 = turn(m2a_s2, m2b_s2);
	assign o3 = turn(m3a_s2, m3b_s2);
	assign o4 = turn(m4a_s2, m4b_s2);
	assign o5 = turn(m5a_s2, m5b_s2);
	assign meet = (o1 != o2 && o3 != o4) || (o1 == 2'd0 && bx1_s2) ||
		(o2 == 2'd0 && bx2_s2) || (o3 == 2'd0 && bx3_s2) || (o4 == 2'd0 && bx4_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			parity_q <= 1'b0;
			stop_q <= 1'b0;
			inside_q <= 1'b0;
		end else begin
			if (cmd.clr) count_q <= '0;
			else if (cmd.wr_vertex) count_q <= count_q + 1'b1;
			if (cmd.latch) begin
				parity_q <= 1'b0;
				stop_q <= 1'b0;
				inside_q <= 1'b0;
			end else if (v_s2 && !stop_q && meet) begin
				if (o5 == 2'd0) begin
					stop_q <= 1'b1;
					inside_q <= bx5_s2;
				end else begin
					parity_q <= ~parity_q;
					inside_q <= ~parity_q;
				end
			end
		end
	end
endmodule

>>> design/pip_ctrl.sv
// sequencer that decodes items and walks the polygon edges
module pip_ctrl #(
	parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
	parameter int IDX_W = $clog2(MAX_VERTICES)
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  pip_pkg::item_t item,
	input  pip_pkg::dp_stat_t stat,
	input  logic inside_q,
	input  logic [IDX_W:0] count_q,
	output pip_pkg::dp_cmd_t cmd,
	output logic [IDX_W-1:0] rd_idx,
	output logic rd_wrap,
	output logic busy,
	output logic done,
	output pip_pkg::result_t result
);
	import pip_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_WALK = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;
	localparam logic [1:0] S_REPLY = 2'd3;

	logic [1:0] state_q;
	logic [IDX_W:0] idx_q;
	logic [1:0] drain_q;
	logic take;
	logic [1:0] st_d;
	logic done_d;

	assign take = start && !busy;
	assign busy = (state_q != S_IDLE);
	assign rd_idx = idx_q[IDX_W-1:0];
	assign rd_wrap = (idx_q + 1'b1 >= count_q);

	always_comb begin
		cmd = '0;
		cmd.latch = take && item.func == FUNC_QUERY && !stat.few;
		cmd.clr = take && item.func == FUNC_CLEAR;
		cmd.wr_vertex = take && item.func == FUNC_APPEND && !stat.full;
		cmd.rd = (state_q == S_WALK);
		cmd.eval = 1'b1;
		st_d = ST_OK;
		done_d = 1'b0;
		if (take) begin
			case (item.func)
				FUNC_APPEND: if (stat.full) st_d = ST_FULL;
				FUNC_QUERY: if (stat.few) st_d = ST_FEW;
				default: st_d = ST_OK;
			endcase
			done_d = !cmd.latch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			drain_q <= '0;
			done <= 1'b0;
			result <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					if (cmd.latch) state_q <= S_WALK;
					if (done_d) begin
						done <= 1'b1;
						result.inside_res <= 1'b0;
						result.status <= st_d;
						result.vertex_count <= CNT_W'(cmd.clr ? '0 :
							count_q + (cmd.wr_vertex ? 1'b1 : 1'b0));
					end
				end
				S_WALK: begin
					idx_q <= idx_q + 1'b1;
					if (rd_wrap || stat.stop) begin
						state_q <= S_DRAIN;
						drain_q <= '0;
					end
				end
				S_DRAIN: begin
					drain_q <= drain_q + 1'b1;
					if (drain_q == 2'd2) state_q <= S_REPLY;
				end
				S_REPLY: begin
					state_q <= S_IDLE;
					done <= 1'b1;
					result.inside_res <= inside_q;
					result.status <= ST_OK;
					result.vertex_count <= CNT_W'(count_q);
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

>>> design/point_in_polygon_test.sv
// point-in-polygon test by ray casting: clear/append/few items are answered from idle with a registered done,
// a query walks the n stored edges (one edge read per cycle) and ends early on a collinear stop
// busy is high only while a query runs, so no new item is taken until its result; results cannot be stalled
// reset clears count, state and ray end x to 10000.0; vertex memory is not cleared
module point_in_polygon_test #(
	parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
	parameter int FRAC_BITS = pip_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  pip_pkg::item_t item,
	output logic busy,
	input  logic cfg_we,
	input  logic signed [pip_pkg::COORD_W-1:0] cfg_wdata,
	output logic done,
	output pip_pkg::result_t result
);
	import pip_pkg::*;

	localparam int IDX_W = $clog2(MAX_VERTICES);
	localparam longint RAY_RAW = 64'sd10000 <<< FRAC_BITS;
	localparam logic signed [COORD_W-1:0] RAY_RESET =
		(RAY_RAW > 64'sd8388607) ? COORD_W'(8388607) : COORD_W'(RAY_RAW);

	logic signed [COORD_W-1:0] ray_end_x_q;
	dp_cmd_t cmd;
	dp_stat_t stat;
	logic inside_q;
	logic [IDX_W:0] count_q;
	logic [IDX_W-1:0] rd_idx;
	logic rd_wrap;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ray_end_x_q <= RAY_RESET;
		else if (cfg_we) ray_end_x_q <= cfg_wdata;
	end

	pip_ctrl #(.MAX_VERTICES(MAX_VERTICES), .IDX_W(IDX_W)) u_ctrl (
		.clk, .arst_n, .start, .item, .stat, .inside_q, .count_q,
		.cmd, .rd_idx, .rd_wrap, .busy, .done, .result
	);

	pip_datapath #(.MAX_VERTICES(MAX_VERTICES), .IDX_W(IDX_W)) u_dp (
		.clk, .arst_n, .cmd, .item, .rd_idx, .rd_wrap,
		.ray_end_x(ray_end_x_q), .stat, .inside_q, .count_q
	);
endmodule

>>> design/pip_checker.sv
// port-level checker for the point-in-polygon test
module pip_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input pip_pkg::item_t item,
	input pip_pkg::result_t result
);
	import pip_pkg::*;
`include "point_in_polygon_test_assert.svh"
	`PIP_ASSERT(a_cnt_range, !done || result.vertex_count <= CNT_W'(64))
	`PIP_ASSERT(a_ins_ok, !done || !result.inside_res || result.status == ST_OK)
	`PIP_ASSERT_NEXT(a_clear, start && !busy && item.func == FUNC_CLEAR, done && result.vertex_count == '0)
endmodule

bind point_in_polygon_test pip_checker u_chk (
	.clk, .arst_n, .start, .busy, .done, .item, .result
);

>>> tb/tb_point_in_polygon_test.sv
// testbench for the point-in-polygon test: directed cases, random polygons and queries checked against a predictor
`timescale 1ns / 1ps
module tb_point_in_polygon_test;
	import pip_pkg::*;

	logic clk;
	logic arst_n;
	logic start;
	item_t item;
	logic busy;
	logic cfg_we;
	logic signed [COORD_W-1:0] cfg_wdata;
	logic done;
	result_t result;

	point_in_polygon_test dut (
		.clk(clk), .arst_n(arst_n), .start(start), .item(item), .busy(busy),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done), .result(result)
	);

	// predictor state
	logic signed [COORD_W-1:0] poly_x [MAX_VERTICES_DEF];
	logic signed [COORD_W-1:0] poly_y [MAX_VERTICES_DEF];
	int unsigned poly_count;
	logic signed [COORD_W-1:0] ray_x;

	item_t pending_items[$];
	result_t expected_results[$];
	int errors;
	bit pause_req;
	bit drv_idle;
	bit beat_taken;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void add_item(item_t it);
		pending_items = {pending_items, it};
	endfunction

	// 0 collinear, 1 clockwise, 2 counterclockwise
	function automatic int turn(longint ax, longint ay, longint bx, longint by,
			longint cx, longint cy);
		longint v;
		v = (by - ay) * (cx - bx) - (bx - ax) * (cy - by);
		if (v == 0) return 0;
		return (v > 0) ? 1 : 2;
	endfunction

	function automatic bit in_box(longint ax, longint ay, longint bx, longint by,
			longint cx, longint cy);
		longint xlo, xhi, ylo, yhi;
		xlo = ax < cx ? ax : cx;
		xhi = ax < cx ? cx : ax;
		ylo = ay < cy ? ay : cy;
		yhi = ay < cy ? cy : ay;
		return bx >= xlo && bx <= xhi && by >= ylo && by <= yhi;
	endfunction

	function automatic bit crosses(longint ax, longint ay, longint bx, longint by,
			longint cx, longint cy, longint dx, longint dy);
		int o1, o2, o3, o4;
		o1 = turn(ax, ay, bx, by, cx, cy);
		o2 = turn(ax, ay, bx, by, dx, dy);
		o3 = turn(cx, cy, dx, dy, ax, ay);
		o4 = turn(cx, cy, dx, dy, bx, by);
		if (o1 != o2 && o3 != o4) return 1;
		if (o1 == 0 && in_box(ax, ay, cx, cy, bx, by)) return 1;
		if (o2 == 0 && in_box(ax, ay, dx, dy, bx, by)) return 1;
		if (o3 == 0 && in_box(cx, cy, ax, ay, dx, dy)) return 1;
		if (o4 == 0 && in_box(cx, cy, bx, by, dx, dy)) return 1;
		return 0;
	endfunction

	function automatic bit point_inside(longint px, longint py);
		int unsigned hits;
		int unsigned j;
		longint ax, ay, bx, by;
		hits = 0;
		for (int unsigned i = 0; i < poly_count; i++) begin
			j = (i + 1 >= poly_count) ? 0 : i + 1;
			ax = poly_x[i];
			ay = poly_y[i];
			bx = poly_x[j];
			by = poly_y[j];
			if (crosses(ax, ay, bx, by, px, py, ray_x, py)) begin
				if (turn(ax, ay, px, py, bx, by) == 0)
					return in_box(ax, ay, px, py, bx, by);
				hits++;
			end
		end
		return hits[0];
	endfunction

	function automatic result_t predict_polygon(item_t it);
		result_t r;
		r = '0;
		case (it.func)
			FUNC_CLEAR: poly_count = 0;
			FUNC_APPEND: begin
				if (poly_count >= MAX_VERTICES_DEF) begin
					r.status = ST_FULL;
				end else begin
					poly_x[poly_count] = it.coord_x;
					poly_y[poly_count] = it.coord_y;
					poly_count++;
				end
			end
			FUNC_QUERY: begin
				if (poly_count < MIN_CORNERS) r.status = ST_FEW;
				else r.inside_res = point_inside(it.coord_x, it.coord_y);
			end
			default: ;
		endcase
		r.vertex_count = poly_count[CNT_W-1:0];
		return r;
	endfunction

	// beat accepted at this edge, seen by the driver at the next falling edge
	always @(posedge clk) begin
		beat_taken = arst_n && start && !busy;
	end

	// driver: bursts with random gaps, hold-off on pause request
	int gap;
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
			gap = 0;
			drv_idle = 1'b1;
		end else if (start && !beat_taken) begin
			// beat not yet taken, hold it
		end else if (gap > 0 || pause_req || pending_items.size() == 0) begin
			if (gap > 0) gap--;
			start <= 1'b0;
			drv_idle = pending_items.size() == 0 || pause_req;
		end else begin
			item <= pending_items[0];
			expected_results = {expected_results, predict_polygon(pending_items.pop_front())};
			start <= 1'b1;
			drv_idle = 1'b0;
			if ($urandom_range(0, 9) == 0) gap = $urandom_range(1, 20);
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$error("result with no expectation: %p", result);
				errors++;
			end else begin
				result_t e;
				e = expected_results.pop_front();
				if (result.inside_res !== e.inside_res) begin
					$error("inside_res expected %0d got %0d", e.inside_res, result.inside_res);
					errors++;
				end
				if (result.status !== e.status) begin
					$error("status expected %0d got %0d", e.status, result.status);
					errors++;
				end
				if (result.vertex_count !== e.vertex_count) begin
					$error("vertex_count expected %0d got %0d", e.vertex_count,
						result.vertex_count);
					errors++;
				end
			end
		end
	end

	function automatic item_t mk(logic [1:0] f, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
		item_t it;
		it.func = f;
		it.coord_x = x;
		it.coord_y = y;
		return it;
	endfunction

	function automatic logic [COORD_W-1:0] rnd_coord(int unsigned span);
		case ($urandom_range(0, 9))
			0: return 24'($urandom);
			1: return $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
			default: return 24'($signed($urandom_range(0, 2 * span)) - int'(span));
		endcase
	endfunction

	// send what is pending, then hold off until every result is back
	task automatic drain();
		while (pending_items.size() != 0 || !drv_idle)
			@(posedge clk);
		pause_req = 1'b1;
		while (expected_results.size() != 0 || busy)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_ray(logic signed [COORD_W-1:0] v);
		@(negedge clk);
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		ray_x = v;
		pause_req = 1'b0;
	endtask

	// random polygons: mostly small well-formed shapes, some noise
	task automatic random_phase(int n, int unsigned span);
		int nv;
		logic [COORD_W-1:0] cx, cy;
		int unsigned r;
		for (int k = 0; k < n; ) begin
			add_item(mk(FUNC_CLEAR, 24'($urandom), 24'($urandom)));
			nv = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 8);
			cx = rnd_coord(span);
			cy = rnd_coord(span);
			r = $urandom_range(1, span);
			for (int v = 0; v < nv; v++) begin
				if ($urandom_range(0, 3) == 0)
					add_item(mk(FUNC_APPEND, rnd_coord(span), rnd_coord(span)));
				else
					add_item(mk(FUNC_APPEND,
						cx + 24'($signed($urandom_range(0, 2 * r)) - int'(r)),
						cy + 24'($signed($urandom_range(0, 2 * r)) - int'(r))));
			end
			for (int q = 0; q < 6; q++) begin
				if ($urandom_range(0, 4) == 0)
					add_item(mk(2'($urandom), rnd_coord(span), rnd_coord(span)));
				else if ($urandom_range(0, 3) == 0 && nv > 0)
					// points on the lower border of the vertex spread box
					add_item(mk(FUNC_QUERY, cx, cy - 24'(r)));
				else
					add_item(mk(FUNC_QUERY,
						cx + 24'($signed($urandom_range(0, 2 * r)) - int'(r)),
						cy + 24'($signed($urandom_range(0, 2 * r)) - int'(r))));
			end
			k += nv + 7;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		errors = 0;
		pause_req = 1'b0;
		drv_idle = 1'b1;
		poly_count = 0;
		ray_x = 24'sd2560000;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: few vertices, square, on edge, on vertex, extremes, unused func
		add_item(mk(FUNC_QUERY, 0, 0));
		add_item(mk(FUNC_APPEND, 0, 0));
		add_item(mk(FUNC_APPEND, 24'd2560, 0));
		add_item(mk(FUNC_QUERY, 24'd10, 0));
		add_item(mk(FUNC_APPEND, 24'd2560, 24'd2560));
		add_item(mk(FUNC_APPEND, 0, 24'd2560));
		add_item(mk(FUNC_QUERY, 24'd256, 24'd256));
		add_item(mk(FUNC_QUERY, 24'd5000, 24'd256));
		add_item(mk(FUNC_QUERY, 0, 24'd100));
		add_item(mk(FUNC_QUERY, 24'd2560, 24'd2560));
		add_item(mk(FUNC_QUERY, 24'd100, 0));
		add_item(mk(FUNC_QUERY, 24'h800000, 24'h7fffff));
		add_item(mk(2'd3, 24'h7fffff, 24'h800000));
		add_item(mk(FUNC_CLEAR, 0, 0));
		add_item(mk(FUNC_APPEND, 24'h800000, 24'h800000));
		add_item(mk(FUNC_APPEND, 24'h7fffff, 24'h800000));
		add_item(mk(FUNC_APPEND, 24'h7fffff, 24'h7fffff));
		add_item(mk(FUNC_QUERY, 24'hffffff, 24'h000001));
		add_item(mk(FUNC_QUERY, 24'h7fffff, 24'h7fffff));
		drain();
		write_ray(24'sh7fffff);
		add_item(mk(FUNC_QUERY, 24'hffffff, 24'h000001));
		for (int v = 0; v < 62; v++) add_item(mk(FUNC_APPEND, 24'(v), 24'(v * v)));
		add_item(mk(FUNC_APPEND, 1, 2));
		add_item(mk(FUNC_QUERY, 24'd10, 24'd50));
		drain();

		write_ray(24'sh800000);
		random_phase(200, 4000);
		drain();
		write_ray(-24'sd3000);
		random_phase(200, 4000);
		drain();
		write_ray(24'sd2560000);
		random_phase(200, 8388607);
		drain();
		write_ray(24'sd700);
		random_phase(200, 1000);
		drain();

		if (errors == 0 && expected_results.size() == 0) begin
			$display("point_in_polygon_test regression: pass");
		end else begin
			$display("point_in_polygon_test regression: fail");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("point_in_polygon_test regression: fail");
		$finish;
	end
endmodule
